// File: hw/rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

// File: hw/rtl/sot_pkg.sv
package sot_pkg;

   // payload length carried by every reference opcode
   localparam int unsigned REF_PAYLOAD_BYTES = 36;

   // opcodes with fixed meaning
   localparam logic [7:0] OP_ZERO      = 8'h00;
   localparam logic [7:0] OP_PUSH_LEN1 = 8'h4c;
   localparam logic [7:0] OP_PUSH_LEN2 = 8'h4d;
   localparam logic [7:0] OP_PUSH_LEN4 = 8'h4e;
   localparam logic [7:0] OP_LAST_PUSH = 8'h60;

   // byte roles on the result channel
   localparam logic [1:0] ROLE_OPCODE  = 2'd0;
   localparam logic [1:0] ROLE_LENGTH  = 2'd1;
   localparam logic [1:0] ROLE_PAYLOAD = 2'd2;

   // register map
   localparam int unsigned CSR_ADDR_WIDTH = 5;
   localparam logic [2:0] REG_PUSH_REF        = 3'd0;
   localparam logic [2:0] REG_REQUIRE_REF     = 3'd1;
   localparam logic [2:0] REG_DISALLOW_REF    = 3'd2;
   localparam logic [2:0] REG_DISALLOW_SIB    = 3'd3;
   localparam logic [2:0] REG_SINGLETON_REF   = 3'd4;
   localparam logic [2:0] REG_MAX_OPCODE      = 3'd5;
   localparam logic [2:0] REG_MAX_ELEMENT     = 3'd6;

   typedef enum logic [1:0] {
      PH_OPCODE  = 2'd0,
      PH_LENGTH  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_of_script;
   } sot_req_type;

   typedef struct packed {
      logic [7:0]  byte_echo;
      logic [1:0]  byte_role;
      logic [7:0]  current_opcode;
      logic [31:0] push_length;
      logic        op_end;
      logic        op_invalid;
      logic        not_push;
      logic        truncated;
   } sot_rsp_type;

   typedef struct packed {
      logic [7:0]  push_ref_op;
      logic [7:0]  require_ref_op;
      logic [7:0]  disallow_ref_op;
      logic [7:0]  disallow_sibling_op;
      logic [7:0]  singleton_ref_op;
      logic [7:0]  max_opcode_value;
      logic [31:0] max_element_bytes;
   } sot_cfg_type;

   // number of little-endian length bytes after a pushdata opcode
   function automatic logic [2:0] length_field_bytes(input logic [7:0] op);
      logic [2:0] n;
      if (op == OP_PUSH_LEN1) begin
         n = 3'd1;
      end else if (op == OP_PUSH_LEN2) begin
         n = 3'd2;
      end else begin
         n = 3'd4;
      end
      return n;
   endfunction

endpackage

// File: hw/rtl/script_opcode_tokenizer.sv
// Script opcode tokenizer.
// Script bytes arrive on the req_ channel (req_valid, req_stall, req_data) one
// word per byte, with last_of_script marking the final byte of each script.
// Every byte yields exactly one word on the rsp_ channel (rsp_valid,
// rsp_stall, rsp_data) tagging it as opcode, length or payload byte, with the
// opcode it belongs to, the push length once known, op end, invalid,
// non-push and truncation flags.
// Each accepted byte passes through the input register, then the decode and
// state update into the result register, which drives rsp_valid.
// Throughput is one byte per cycle while rsp_stall is low; the phase and
// counter registers update on the edge that loads the result register.
// When rsp_stall is held, the result register keeps its word, the input
// register fills, and req_stall rises until the result is taken. Reset
// clears both valid flags, the parser state and the csr_ registers to their
// defaults; the parser restarts after every last_of_script byte. The user must
// write registers via csr_ only while the block is idle; it is not enforced.
module script_opcode_tokenizer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sot_pkg::sot_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sot_pkg::sot_rsp_type                rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sot_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   sot_pkg::sot_cfg_type cfg;
   sot_pkg::sot_req_type in_word_ff;
   sot_pkg::sot_rsp_type rsp_word_ff;
   sot_pkg::sot_rsp_type step_word;
   logic                 in_valid_ff, in_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 advance;
   logic                 take_in;

   sot_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sot_step u_step (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .word_in  (in_word_ff),
      .cfg      (cfg),
      .word_out (step_word)
   );

   // handshake between input and result registers
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take_in   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take_in) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take_in) begin
         in_word_ff <= req_data;
      end
      if (advance) begin
         rsp_word_ff <= step_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

endmodule

// File: hw/rtl/sot_csr.sv
module sot_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sot_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready,
   output sot_pkg::sot_cfg_type                cfg
);

   sot_pkg::sot_cfg_type cfg_ff;
   sot_pkg::sot_cfg_type cfg_in;
   logic [2:0]           reg_index;
   logic                 wr_en;

   assign reg_index  = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            sot_pkg::REG_PUSH_REF:      cfg_in.push_ref_op         = csr_pwdata[7:0];
            sot_pkg::REG_REQUIRE_REF:   cfg_in.require_ref_op      = csr_pwdata[7:0];
            sot_pkg::REG_DISALLOW_REF:  cfg_in.disallow_ref_op     = csr_pwdata[7:0];
            sot_pkg::REG_DISALLOW_SIB:  cfg_in.disallow_sibling_op = csr_pwdata[7:0];
            sot_pkg::REG_SINGLETON_REF: cfg_in.singleton_ref_op    = csr_pwdata[7:0];
            sot_pkg::REG_MAX_OPCODE:    cfg_in.max_opcode_value    = csr_pwdata[7:0];
            sot_pkg::REG_MAX_ELEMENT:   cfg_in.max_element_bytes   = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.push_ref_op         <= 8'd208;
         cfg_ff.require_ref_op      <= 8'd209;
         cfg_ff.disallow_ref_op     <= 8'd210;
         cfg_ff.disallow_sibling_op <= 8'd211;
         cfg_ff.singleton_ref_op    <= 8'd216;
         cfg_ff.max_opcode_value    <= 8'd255;
         cfg_ff.max_element_bytes   <= 32'd520;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      unique case (reg_index)
         sot_pkg::REG_PUSH_REF:      csr_prdata = {24'd0, cfg_ff.push_ref_op};
         sot_pkg::REG_REQUIRE_REF:   csr_prdata = {24'd0, cfg_ff.require_ref_op};
         sot_pkg::REG_DISALLOW_REF:  csr_prdata = {24'd0, cfg_ff.disallow_ref_op};
         sot_pkg::REG_DISALLOW_SIB:  csr_prdata = {24'd0, cfg_ff.disallow_sibling_op};
         sot_pkg::REG_SINGLETON_REF: csr_prdata = {24'd0, cfg_ff.singleton_ref_op};
         sot_pkg::REG_MAX_OPCODE:    csr_prdata = {24'd0, cfg_ff.max_opcode_value};
         sot_pkg::REG_MAX_ELEMENT:   csr_prdata = cfg_ff.max_element_bytes;
         default:                    csr_prdata = 32'd0;
      endcase
   end

endmodule

// File: hw/rtl/sot_step.sv
`include "assert_macros.svh"

module sot_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  sot_pkg::sot_req_type word_in,
   input  sot_pkg::sot_cfg_type cfg,
   output sot_pkg::sot_rsp_type word_out
);

   sot_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  held_opcode_ff, held_opcode_in;
   logic [2:0]  length_left_ff, length_left_in;
   logic [31:0] length_accum_ff, length_accum_in;
   logic [31:0] payload_left_ff, payload_left_in;

   logic [7:0]  b;
   logic        last;
   logic [2:0]  total_len;
   logic [1:0]  lane;
   logic [31:0] accum_new;
   logic        is_ref;
   logic [1:0]  role;
   logic [7:0]  opcode;
   logic [31:0] plen;
   logic        end_op;

   assign b    = word_in.byte_value;
   assign last = word_in.last_of_script;

   // merge the incoming length byte into its lane
   assign total_len = sot_pkg::length_field_bytes(held_opcode_ff);
   assign lane      = 2'(total_len - length_left_ff);
   always_comb begin
      accum_new = length_accum_ff;
      unique case (lane)
         2'd0:    accum_new[7:0]   = length_accum_ff[7:0]   | b;
         2'd1:    accum_new[15:8]  = length_accum_ff[15:8]  | b;
         2'd2:    accum_new[23:16] = length_accum_ff[23:16] | b;
         default: accum_new[31:24] = length_accum_ff[31:24] | b;
      endcase
   end

   // reference opcode match
   assign is_ref = (b == cfg.push_ref_op) || (b == cfg.require_ref_op) ||
                   (b == cfg.disallow_ref_op) || (b == cfg.disallow_sibling_op) ||
                   (b == cfg.singleton_ref_op);

   // result decode for the current byte
   always_comb begin
      role   = sot_pkg::ROLE_OPCODE;
      opcode = b;
      plen   = 32'd0;
      end_op = 1'b0;
      unique case (phase_ff)
         sot_pkg::PH_LENGTH: begin
            role   = sot_pkg::ROLE_LENGTH;
            opcode = held_opcode_ff;
            if (length_left_ff == 3'd1) begin
               plen   = accum_new;
               end_op = (accum_new == 32'd0);
            end
         end
         sot_pkg::PH_PAYLOAD: begin
            role   = sot_pkg::ROLE_PAYLOAD;
            opcode = held_opcode_ff;
            plen   = (held_opcode_ff <= sot_pkg::OP_PUSH_LEN4) ? length_accum_ff
                                                              : 32'(sot_pkg::REF_PAYLOAD_BYTES);
            end_op = (payload_left_ff == 32'd1);
         end
         default: begin
            if (b < sot_pkg::OP_PUSH_LEN1) begin
               plen   = {24'd0, b};
               end_op = (b == sot_pkg::OP_ZERO);
            end else if (b <= sot_pkg::OP_PUSH_LEN4) begin
               end_op = 1'b0;
            end else if (is_ref) begin
               plen = 32'(sot_pkg::REF_PAYLOAD_BYTES);
            end else begin
               end_op = 1'b1;
            end
         end
      endcase
   end

   // result word
   always_comb begin
      word_out.byte_echo      = b;
      word_out.byte_role      = role;
      word_out.current_opcode = opcode;
      word_out.push_length    = plen;
      word_out.op_end         = end_op;
      word_out.op_invalid     = end_op && ((opcode > cfg.max_opcode_value) ||
                                           (plen > cfg.max_element_bytes));
      word_out.not_push       = end_op && (opcode > sot_pkg::OP_LAST_PUSH);
      word_out.truncated      = !end_op && last;
   end

   // next state
   always_comb begin
      phase_in        = phase_ff;
      held_opcode_in  = held_opcode_ff;
      length_left_in  = length_left_ff;
      length_accum_in = length_accum_ff;
      payload_left_in = payload_left_ff;
      unique case (phase_ff)
         sot_pkg::PH_LENGTH: begin
            length_accum_in = accum_new;
            length_left_in  = length_left_ff - 3'd1;
            if (length_left_ff == 3'd1 && accum_new != 32'd0) begin
               phase_in        = sot_pkg::PH_PAYLOAD;
               payload_left_in = accum_new;
            end
         end
         sot_pkg::PH_PAYLOAD: begin
            payload_left_in = payload_left_ff - 32'd1;
         end
         default: begin
            held_opcode_in  = b;
            length_accum_in = 32'd0;
            if (b < sot_pkg::OP_PUSH_LEN1) begin
               length_accum_in = {24'd0, b};
               if (b != sot_pkg::OP_ZERO) begin
                  phase_in        = sot_pkg::PH_PAYLOAD;
                  payload_left_in = {24'd0, b};
               end
            end else if (b <= sot_pkg::OP_PUSH_LEN4) begin
               phase_in       = sot_pkg::PH_LENGTH;
               length_left_in = sot_pkg::length_field_bytes(b);
            end else if (is_ref) begin
               phase_in        = sot_pkg::PH_PAYLOAD;
               payload_left_in = 32'(sot_pkg::REF_PAYLOAD_BYTES);
            end
         end
      endcase
      if (end_op) begin
         phase_in        = sot_pkg::PH_OPCODE;
         length_left_in  = 3'd0;
         payload_left_in = 32'd0;
      end
      // end of script starts the next one afresh
      if (last) begin
         phase_in        = sot_pkg::PH_OPCODE;
         held_opcode_in  = 8'd0;
         length_left_in  = 3'd0;
         length_accum_in = 32'd0;
         payload_left_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= sot_pkg::PH_OPCODE;
         held_opcode_ff  <= 8'd0;
         length_left_ff  <= 3'd0;
         length_accum_ff <= 32'd0;
         payload_left_ff <= 32'd0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         held_opcode_ff  <= held_opcode_in;
         length_left_ff  <= length_left_in;
         length_accum_ff <= length_accum_in;
         payload_left_ff <= payload_left_in;
      end
   end

   // checks
   `ASSERT_HOLDS(a_last_restarts, clock, reset,
                 (step_en && last) |=> (phase_ff == sot_pkg::PH_OPCODE))
   `ASSERT_NEVER(a_payload_count_live, clock, reset,
                 (phase_ff == sot_pkg::PH_PAYLOAD) && (payload_left_ff == 32'd0))
   `ASSERT_HOLDS(a_length_count_range, clock, reset,
                 (phase_ff == sot_pkg::PH_LENGTH) |->
                 ((length_left_ff != 3'd0) && (length_left_ff <= 3'd4)))

endmodule
